// ----- rtl/ftc_pkg.sv -----
// Package for flux transition compensation: codes, constants, types and the zone factor table.
package ftc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned ThW      = 17;
  localparam int unsigned DenW     = 15;
  localparam int unsigned RcpW     = 22;
  localparam int unsigned ThProdW  = TimeW + RcpW;
  localparam int unsigned PeakW    = 40;
  localparam int unsigned StepW    = 2;
  localparam int unsigned FactorW  = 18;
  localparam int unsigned ProdW    = TimeW + FactorW;
  localparam int unsigned QuotW    = 29;
  localparam int unsigned Stages   = 9;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW     = 2;
  localparam int unsigned CountW   = 3;

  localparam logic [2:0] MODE_PASS = 3'd0;
  localparam logic [2:0] MODE_PEAK = 3'd1;
  localparam logic [2:0] MODE_ZONE = 3'd2;
  localparam logic [2:0] MODE_MFM  = 3'd3;
  localparam logic [2:0] MODE_GCR  = 3'd4;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_SPR   = 2'd1;
  localparam logic [1:0] CFG_TRACK = 2'd2;
  localparam logic [1:0] CFG_GCR   = 2'd3;

  localparam logic [31:0] SprReset   = 32'd100000;
  localparam logic [7:0]  TrackCap   = 8'd47;
  localparam logic [7:0]  PeakBase   = 8'd160;
  localparam logic [PeakW-1:0] PeakRound = 40'd3600000;

  // Split each divisor into a power of two and an odd part:
  // 7200000 = 256 * 28125, 60000 = 32 * 1875, 50000 = 16 * 3125, 125000 = 8 * 15625.
  localparam int unsigned PeakShift  = 8;
  localparam int unsigned MfmShift   = 5;
  localparam int unsigned Gcr62Shift = 4;
  localparam int unsigned Gcr53Shift = 3;
  localparam logic [DenW-1:0] DenPeak  = 15'd28125;
  localparam logic [DenW-1:0] DenMfm   = 15'd1875;
  localparam logic [DenW-1:0] DenGcr62 = 15'd3125;
  localparam logic [DenW-1:0] DenGcr53 = 15'd15625;
  localparam logic [RcpW-1:0] RcpPeak  = 22'd152709;
  localparam logic [RcpW-1:0] RcpMfm   = 22'd2290649;
  localparam logic [RcpW-1:0] RcpGcr62 = 22'd1374389;
  localparam logic [RcpW-1:0] RcpGcr53 = 22'd274877;

  localparam logic [StepW-1:0] ThMul  = 2'd1;
  localparam logic [StepW-1:0] ThSub  = 2'd2;
  localparam logic [StepW-1:0] ThLast = 2'd3;

  localparam logic [31:0] Recip12    = 32'hAAAAAAAB;

  typedef enum logic [1:0] {
    TH_IDLE,
    TH_PEAK,
    TH_MFM,
    TH_GCR
  } th_state_t;

  typedef struct packed {
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] t1;
    logic [TimeW-1:0] direct;
    logic [1:0]       pos;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0] value;
    logic             last;
    logic             err;
  } result_t;

  function automatic logic [FactorW-1:0] zone_factor(input logic [7:0] track);
    logic [FactorW-1:0] f;
    if (track >= 8'd31) f = 18'd150077;
    else if (track >= 8'd25) f = 18'd163840;
    else if (track >= 8'd18) f = 18'd174981;
    else f = 18'd196608;
    return f;
  endfunction

endpackage

// ----- rtl/flux_transition_compensation_top.sv -----
// Flux transition compensation: threshold unit, nine-stage correction pipeline, result queue.
//
// Takes one transition beat per cycle while item_stall is low and writes results into a
// four-entry queue; the pipeline holds while a beat waits at the last stage and the queue
// has fewer than two free entries. result_valid rises once a beat's result has left stage
// 8 for the queue. Peak-shift and MFM modes answer one beat late, and the last beat of a
// run longer than one beat gives two results, which the queue drains at one per cycle
// while result_stall is low. After reset and after every configuration write the three
// thresholds are recomputed by reciprocal multiplication, and item_stall is high meanwhile.
module flux_transition_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] transition_time,
  input  logic        last_item,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] corrected_time,
  output logic        last_result,
  output logic        run_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ftc_pkg::*;

  logic [2:0]  comp_mode;
  logic [31:0] ticks_per_rev;
  logic [7:0]  track_number;
  logic        gcr_encoding;

  logic [TimeW-1:0] older_input;
  logic [TimeW-1:0] previous_input;
  logic [TimeW-1:0] previous_output;
  logic [1:0]       position_count;

  th_state_t          th_state, th_state_next;
  logic [StepW-1:0]   th_step;
  logic [TimeW-1:0]   th_num;
  logic [RcpW-1:0]    th_rcp;
  logic [DenW-1:0]    th_den;
  logic [ThW-1:0]     th_qest;
  logic [TimeW-1:0]   th_rem;
  logic [ThW-1:0]     th_quot;
  logic [ThProdW-1:0] th_prod;
  logic [ThW-1:0]     th_peak, thr_mfm, thr_gcr;
  logic               th_load, th_done, th_busy;
  logic [TimeW-1:0]   num_sel;
  logic [RcpW-1:0]    rcp_sel;
  logic [DenW-1:0]    den_sel;
  logic [PeakW-1:0]   peak_num;
  logic [TimeW+1:0]   gcr53_num;
  logic [7:0]         peak_mult;
  logic               cfg_write;

  logic              adv, accept;
  logic [Stages-1:0] stage_valid;
  item_t             pipe [Stages];

  logic [TimeW-1:0] s0_t0;
  logic [TimeW-1:0] s0_d01, s0_nd01, s0_d12, s0_r;
  logic             s0_mfm_ok, s0_gcr_short;
  logic [ProdW-1:0] s0_prod;

  logic [TimeW-1:0] s1_d01, s1_nd01, s1_d12, s1_r;
  logic [ProdW-1:0] s1_prod;
  logic             s1_mfm_ok;
  logic [TimeW-1:0] s1_e1, s1_e2, s1_lo, s1_hi, s1_mdiff, s1_direct, s1_zone;
  logic [TimeW-1:0] s1_lo_sum, s1_hi_sum;
  item_t            s1_item;

  logic [TimeW-1:0] s2_e1, s2_e2, s2_mdiff;
  logic             s2_mfm_ok;
  logic [TimeW-1:0] s2_ediff, s2_mq, s2_msum;

  logic [TimeW-1:0] s3_ediff, s3_mq;
  logic [TimeW-1:0] s3_x, s3_mfm;

  logic [TimeW-1:0] s4_x;
  logic [TimeW-1:0] s4_ax;

  logic [TimeW-1:0] s5_ax;
  logic             s5_neg;
  logic [63:0]      s5_prod;

  logic [QuotW-1:0] s6_q;
  logic             s6_neg;
  logic [TimeW-1:0] s6_sq;

  logic [TimeW-1:0] s7_sq;
  logic [TimeW-1:0] s7_sh;

  logic [TimeW-1:0] s8_sh;
  logic [TimeW-1:0] s8_fix;

  logic [TimeW-1:0] lo_line  [2:7];
  logic [TimeW-1:0] hi_line  [2:7];
  logic [TimeW-1:0] mfm_line [4:8];

  result_t          res0, res1;
  logic             has0, has1, push0, push1, pop;
  result_t          fifo [FifoDepth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CountW-1:0] count, count_next;
  logic             window, err_mode;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_mode     <= MODE_PASS;
      ticks_per_rev <= SprReset;
      track_number  <= '0;
      gcr_encoding  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE:  comp_mode     <= cfg_data[2:0];
        CFG_SPR:   ticks_per_rev <= cfg_data;
        CFG_TRACK: track_number  <= cfg_data[7:0];
        CFG_GCR:   gcr_encoding  <= cfg_data[0];
        default:   comp_mode     <= comp_mode;
      endcase
    end
  end

  // Threshold sequencer
  always_comb begin
    th_state_next = th_state;
    if (cfg_write) begin
      th_state_next = TH_PEAK;
    end else begin
      case (th_state)
        TH_IDLE: th_state_next = TH_IDLE;
        TH_PEAK: if (th_done) th_state_next = TH_MFM;
        TH_MFM:  if (th_done) th_state_next = TH_GCR;
        TH_GCR:  if (th_done) th_state_next = TH_IDLE;
        default: th_state_next = TH_IDLE;
      endcase
    end
  end

  always_comb begin
    th_busy   = th_state != TH_IDLE;
    th_load   = th_busy && th_step == '0;
    th_done   = th_busy && th_step == ThLast;
    peak_mult = (track_number < TrackCap ? track_number : TrackCap) + PeakBase;
    peak_num  = PeakW'(ticks_per_rev) * PeakW'(peak_mult) + PeakRound;
    gcr53_num = {1'b0, ticks_per_rev, 1'b0} + {2'b00, ticks_per_rev};
    case (th_state)
      TH_PEAK: begin
        num_sel = peak_num[PeakW-1:PeakShift];
        rcp_sel = RcpPeak;
        den_sel = DenPeak;
      end
      TH_MFM: begin
        num_sel = ticks_per_rev >> MfmShift;
        rcp_sel = RcpMfm;
        den_sel = DenMfm;
      end
      TH_GCR: begin
        num_sel = gcr_encoding ? ticks_per_rev >> Gcr62Shift
                               : TimeW'(gcr53_num >> Gcr53Shift);
        rcp_sel = gcr_encoding ? RcpGcr62 : RcpGcr53;
        den_sel = gcr_encoding ? DenGcr62 : DenGcr53;
      end
      default: begin
        num_sel = '0;
        rcp_sel = RcpMfm;
        den_sel = DenMfm;
      end
    endcase
  end

  // Estimate is the quotient or one below it; one compare settles it
  always_comb begin
    th_prod = ThProdW'(th_num) * ThProdW'(th_rcp);
    th_quot = th_qest + ThW'(th_rem >= TimeW'(th_den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      th_state <= TH_PEAK;
      th_step  <= '0;
    end else begin
      th_state <= th_state_next;
      if (cfg_write || th_done || !th_busy) th_step <= '0;
      else th_step <= th_step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (th_load) begin
      th_num <= num_sel;
      th_rcp <= rcp_sel;
      th_den <= den_sel;
    end
    if (th_busy && th_step == ThMul) th_qest <= th_prod[TimeW+ThW-1:TimeW];
    if (th_busy && th_step == ThSub) th_rem <= th_num - TimeW'(th_qest) * TimeW'(th_den);
    if (th_done) begin
      case (th_state)
        TH_PEAK: th_peak <= th_quot;
        TH_MFM:  thr_mfm <= th_quot;
        TH_GCR:  thr_gcr <= th_quot;
        default: th_peak <= th_peak;
      endcase
    end
  end

  // Window state and input beat
  assign adv        = !stage_valid[Stages-1] || count <= CountW'(FifoDepth - 2);
  assign item_stall = !adv || th_busy;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      older_input    <= '0;
      previous_input <= '0;
      position_count <= '0;
    end else if (accept) begin
      older_input    <= previous_input;
      previous_input <= transition_time;
      if (last_item) position_count <= '0;
      else if (position_count != 2'd3) position_count <= position_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[Stages-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= '{t: transition_time, t1: previous_input, direct: transition_time,
                   pos: position_count, last: last_item};
      s0_t0   <= older_input;
      pipe[1] <= pipe[0];
      pipe[2] <= s1_item;
      for (int k = 3; k < Stages; k++) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  // Stage 0: deltas, gcr pulse fix, zone product
  always_comb begin
    s0_d01       = pipe[0].t1 - s0_t0;
    s0_nd01      = s0_t0 - pipe[0].t1;
    s0_d12       = pipe[0].t - pipe[0].t1;
    s0_mfm_ok    = $signed(s0_d01) < $signed({15'b0, thr_mfm})
                && $signed(s0_d12) < $signed({15'b0, thr_mfm});
    s0_gcr_short = pipe[0].pos != 2'd0 && $signed(s0_d12) < $signed({15'b0, thr_gcr});
    s0_r         = s0_gcr_short ? previous_output + TimeW'(thr_gcr) : pipe[0].t;
    s0_prod      = ProdW'(pipe[0].t) * ProdW'(zone_factor(track_number));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_output <= '0;
    end else if (adv && stage_valid[0] && comp_mode == MODE_GCR) begin
      previous_output <= s0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d01    <= s0_d01;
      s1_nd01   <= s0_nd01;
      s1_d12    <= s0_d12;
      s1_r      <= s0_r;
      s1_prod   <= s0_prod;
      s1_mfm_ok <= s0_mfm_ok;
    end
  end

  // Stage 1: peak excesses, clamp bounds, single-result value
  always_comb begin
    s1_e1     = $signed(s1_d01) < $signed({15'b0, th_peak})
              ? TimeW'({15'b0, th_peak}) - s1_d01 : '0;
    s1_e2     = $signed(s1_d12) < $signed({15'b0, th_peak})
              ? TimeW'({15'b0, th_peak}) - s1_d12 : '0;
    s1_lo_sum = s1_nd01 + TimeW'(s1_nd01[TimeW-1]);
    s1_hi_sum = s1_d12 + TimeW'(s1_d12[TimeW-1]);
    s1_lo     = TimeW'($signed(s1_lo_sum) >>> 1);
    s1_hi     = TimeW'($signed(s1_hi_sum) >>> 1);
    s1_mdiff  = s1_d12 - s1_d01;
    s1_zone   = (s1_prod[ProdW-1:ProdW-2] != 2'b00) ? '1 : s1_prod[ProdW-3:16];
    case (comp_mode)
      MODE_ZONE: s1_direct = s1_zone;
      MODE_GCR:  s1_direct = s1_r;
      default:   s1_direct = pipe[1].t;
    endcase
    s1_item        = pipe[1];
    s1_item.direct = s1_direct;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_e1      <= s1_e1;
      s2_e2      <= s1_e2;
      s2_mdiff   <= s1_mdiff;
      s2_mfm_ok  <= s1_mfm_ok;
      lo_line[2] <= s1_lo;
      hi_line[2] <= s1_hi;
      for (int k = 3; k <= 7; k++) begin
        lo_line[k] <= lo_line[k-1];
        hi_line[k] <= hi_line[k-1];
      end
    end
  end

  // Stage 2: excess difference, mfm quarter shift
  always_comb begin
    s2_ediff = s2_e2 - s2_e1;
    s2_msum  = s2_mdiff + TimeW'({2{s2_mdiff[TimeW-1]}});
    s2_mq    = s2_mfm_ok ? TimeW'($signed(s2_msum) >>> 2) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ediff <= s2_ediff;
      s3_mq    <= s2_mq;
    end
  end

  // Stage 3: times five, mfm result
  always_comb begin
    s3_x   = {s3_ediff[TimeW-3:0], 2'b00} + s3_ediff;
    s3_mfm = pipe[3].t1 + s3_mq;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_x        <= s3_x;
      mfm_line[4] <= s3_mfm;
      for (int k = 5; k <= 8; k++) begin
        mfm_line[k] <= mfm_line[k-1];
      end
    end
  end

  // Stages 4 to 6: signed divide by twelve, truncating
  assign s4_ax = s4_x[TimeW-1] ? TimeW'(-s4_x) : s4_x;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ax  <= s4_ax;
      s5_neg <= s4_x[TimeW-1];
    end
  end

  assign s5_prod = 64'(s5_ax) * 64'(Recip12);

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_q   <= s5_prod[63:35];
      s6_neg <= s5_neg;
    end
  end

  assign s6_sq = s6_neg ? TimeW'(-{3'b000, s6_q}) : TimeW'({3'b000, s6_q});

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_sq <= s6_sq;
    end
  end

  // Stage 7: clamp to half of each neighbor interval
  always_comb begin
    s7_sh = s7_sq;
    if ($signed(s7_sh) < $signed(lo_line[7])) s7_sh = lo_line[7];
    if ($signed(s7_sh) > $signed(hi_line[7])) s7_sh = hi_line[7];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_sh <= s7_sh;
    end
  end

  // Stage 8: assemble results
  always_comb begin
    window   = comp_mode == MODE_PEAK || comp_mode == MODE_MFM;
    err_mode = comp_mode == MODE_PEAK;
    s8_fix   = err_mode ? pipe[8].t1 + s8_sh : mfm_line[8];
    res0     = '{value: pipe[8].direct, last: pipe[8].last, err: 1'b0};
    res1     = '{value: pipe[8].t, last: 1'b1, err: 1'b0};
    has0     = 1'b1;
    has1     = 1'b0;
    if (window) begin
      case (pipe[8].pos)
        2'd0: begin
          res0 = '{value: pipe[8].t, last: 1'b1, err: err_mode};
          has0 = pipe[8].last;
        end
        2'd1: begin
          res0 = '{value: pipe[8].t1, last: 1'b0, err: 1'b0};
          res1 = '{value: pipe[8].t, last: 1'b1, err: err_mode};
          has1 = pipe[8].last;
        end
        default: begin
          res0 = '{value: s8_fix, last: 1'b0, err: 1'b0};
          has1 = pipe[8].last;
        end
      endcase
    end
  end

  // Result queue
  assign push0 = adv && stage_valid[Stages-1] && has0;
  assign push1 = push0 && has1;
  assign result_valid = count != '0;
  assign pop = result_valid && !result_stall;
  assign count_next = count + CountW'(push0) + CountW'(push1) - CountW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push0) + PtrW'(push1);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) fifo[wr_ptr] <= res0;
    if (push1) fifo[PtrW'(wr_ptr + 1'b1)] <= res1;
  end

  assign corrected_time = fifo[rd_ptr].value;
  assign last_result    = fifo[rd_ptr].last;
  assign run_error      = fifo[rd_ptr].err;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(FifoDepth))
    else $error("result queue overflow");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> th_state == TH_PEAK && th_step == '0)
    else $error("threshold pass not restarted after config write");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !th_busy |-> th_step == '0)
    else $error("threshold step counter running while idle");

  a_err_on_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_error |-> last_result)
    else $error("run error on a result that is not the last");

  a_no_item_busy: assert property (@(posedge clk) disable iff (rst)
    th_busy |-> !stage_valid[0] || $past(th_state) != TH_IDLE || $past(cfg_valid))
    else $error("item entered while thresholds were being computed");

endmodule
